### rtl/kway_note_merge_defines.svh
// Assertion macros for the note merge block.
// Used by kway_note_merge; no other dependencies.
`ifndef KWAY_NOTE_MERGE_DEFINES_SVH
`define KWAY_NOTE_MERGE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define KWM_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define KWM_ASSERT(lbl, expr, msg)
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/kwm_pkg.sv
// Shared types and codes for the note merge block.
// No dependencies.
package kwm_pkg;

	typedef struct packed {
		logic [15:0] track;
		logic [3:0]  channel;
		logic [6:0]  key;
		logic [6:0]  velocity;
		logic [31:0] tick;
		logic [31:0] gate;
	} note_rec_t;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

### rtl/kwm_store.sv
// Record memory holding every slot list, one write and one read per cycle.
// Depends on kwm_pkg.
module kwm_store import kwm_pkg::*; #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  note_rec_t         wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output note_rec_t         rd_data
);

	note_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/kwm_select.sv
// Stable minimum search over the list heads; ties go to the lower slot.
// Depends on kwm_pkg.
module kwm_select import kwm_pkg::*; #(
	parameter int NUM_SLOTS = 16,
	parameter int SLOT_W    = 4
) (
	input  logic [NUM_SLOTS-1:0] vld,
	input  logic [31:0]          tick [NUM_SLOTS],
	output logic                 found,
	output logic [SLOT_W-1:0]    win
);

	localparam int P = 1 << SLOT_W;

	logic              v  [P];
	logic [31:0]       t  [P];
	logic [SLOT_W-1:0] ix [P];

	always_comb begin
		for (int i = 0; i < P; i++) begin
			if (i < NUM_SLOTS) begin
				v[i] = vld[i];
				t[i] = tick[i];
			end else begin
				v[i] = 1'b0;
				t[i] = '0;
			end
			ix[i] = SLOT_W'(i);
		end
		for (int l = 0; l < SLOT_W; l++) begin
			for (int i = 0; i < P; i = i + (2 << l)) begin
				if (v[i + (1 << l)] && (!v[i] || t[i + (1 << l)] < t[i])) begin
					v[i]  = 1'b1;
					t[i]  = t[i + (1 << l)];
					ix[i] = ix[i + (1 << l)];
				end
			end
		end
		found = v[0];
		win   = ix[0];
	end

endmodule

### rtl/kway_note_merge.sv
// Stable k-way merge of per-slot note FIFOs ordered by tick.
// Pipeline: an accepted command is held in stage s1; its result is registered when s1 advances.
// Throughput: one transaction per cycle while rsp_stall allows; head records live in
// registers; a refill read of the two-port record memory is forwarded to the next command.
// Reset: all lists empty at once; record memory is not cleared.
`include "kway_note_merge_defines.svh"
module kway_note_merge import kwm_pkg::*; #(
	parameter int NUM_SLOTS  = 16,
	parameter int LIST_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        cmd,
	input  logic [3:0]  slot,
	input  logic [15:0] note_track,
	input  logic [3:0]  note_channel,
	input  logic [31:0] note_tick,
	input  logic [6:0]  note_key,
	input  logic [31:0] note_gate,
	input  logic [6:0]  note_velocity,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [3:0]  out_slot,
	output logic [15:0] out_track,
	output logic [3:0]  out_channel,
	output logic [31:0] out_tick,
	output logic [6:0]  out_key,
	output logic [31:0] out_gate,
	output logic [6:0]  out_velocity
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int PTR_W  = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int DEPTH  = NUM_SLOTS * LIST_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);

	logic        valid_s1;
	logic        cmd_s1;
	logic [3:0]  slot_s1;
	note_rec_t   rec_s1;

	logic [PTR_W-1:0] hptr_q [NUM_SLOTS];
	logic [PTR_W-1:0] tptr_q [NUM_SLOTS];
	logic [CNT_W-1:0] cnt_q  [NUM_SLOTS];
	note_rec_t        hrec_q [NUM_SLOTS];

	logic              rf_pend_q;
	logic [SLOT_W-1:0] rf_slot_q;
	note_rec_t         rd_rec;

	logic              rsp_valid_q;
	logic [1:0]        status_q;
	logic [3:0]        slot_q;
	note_rec_t         rec_q;

	logic              adv;
	logic              is_pop;
	logic              slot_ok;
	logic [SLOT_W-1:0] sidx;
	logic              full;
	logic              push_ok;
	logic              pop_ok;
	logic              refill;
	logic [NUM_SLOTS-1:0] vld;
	logic [31:0]       htick [NUM_SLOTS];
	note_rec_t         hview [NUM_SLOTS];
	logic              found;
	logic [SLOT_W-1:0] win;
	note_rec_t         win_rec;
	logic [PTR_W-1:0]  tail_nxt;
	logic [PTR_W-1:0]  head_nxt;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1          <= cmd;
			slot_s1         <= slot;
			rec_s1.track    <= note_track;
			rec_s1.channel  <= note_channel;
			rec_s1.key      <= note_key;
			rec_s1.velocity <= note_velocity;
			rec_s1.tick     <= note_tick;
			rec_s1.gate     <= note_gate;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hview[i] = (rf_pend_q && rf_slot_q == SLOT_W'(i)) ? rd_rec : hrec_q[i];
			vld[i]   = cnt_q[i] != '0;
			htick[i] = hview[i].tick;
		end
	end

	kwm_select #(
		.NUM_SLOTS (NUM_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_select (
		.vld   (vld),
		.tick  (htick),
		.found (found),
		.win   (win)
	);

	assign is_pop   = cmd_s1 == CMD_POP;
	assign slot_ok  = 32'(slot_s1) < 32'(NUM_SLOTS);
	assign sidx     = SLOT_W'(slot_s1);
	assign full     = cnt_q[sidx] == CNT_W'(LIST_DEPTH);
	assign push_ok  = !is_pop && slot_ok && !full;
	assign pop_ok   = is_pop && found;
	assign refill   = adv && pop_ok && cnt_q[win] != CNT_W'(1);
	assign win_rec  = hview[win];
	assign tail_nxt = ptr_inc(tptr_q[sidx]);
	assign head_nxt = ptr_inc(hptr_q[win]);
	assign wr_addr  = ADDR_W'(sidx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(tptr_q[sidx]);
	assign rd_addr  = ADDR_W'(win) * ADDR_W'(LIST_DEPTH) + ADDR_W'(head_nxt);

	kwm_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (adv && push_ok),
		.wr_addr (wr_addr),
		.wr_data (rec_s1),
		.rd_en   (refill),
		.rd_addr (rd_addr),
		.rd_data (rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				hptr_q[i] <= '0;
				tptr_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			rf_pend_q <= 1'b0;
		end else begin
			rf_pend_q <= refill;
			if (adv && push_ok) begin
				tptr_q[sidx] <= tail_nxt;
				cnt_q[sidx]  <= cnt_q[sidx] + 1'b1;
			end
			if (adv && pop_ok) begin
				hptr_q[win] <= head_nxt;
				cnt_q[win]  <= cnt_q[win] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (refill) begin
			rf_slot_q <= win;
		end
		if (rf_pend_q) begin
			hrec_q[rf_slot_q] <= rd_rec;
		end
		if (adv && push_ok && cnt_q[sidx] == '0) begin
			hrec_q[sidx] <= rec_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!is_pop) begin
				status_q <= push_ok ? ST_OK : ST_FULL;
				slot_q   <= slot_s1;
				rec_q    <= '0;
			end else if (found) begin
				status_q <= ST_OK;
				slot_q   <= 4'(win);
				rec_q    <= win_rec;
			end else begin
				status_q <= ST_EMPTY;
				slot_q   <= '0;
				rec_q    <= '0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign out_slot     = slot_q;
	assign out_track    = rec_q.track;
	assign out_channel  = rec_q.channel;
	assign out_tick     = rec_q.tick;
	assign out_key      = rec_q.key;
	assign out_gate     = rec_q.gate;
	assign out_velocity = rec_q.velocity;

	`KWM_ASSERT(a_win_valid, !found || vld[win], "winner slot is empty")
	`KWM_ASSERT(a_refill_live, !rf_pend_q || cnt_q[rf_slot_q] != '0, "refill of empty list")
	`KWM_ASSERT_NEXT(a_full_flag, adv && !is_pop && full, status == ST_FULL, "full push not flagged")
	`KWM_ASSERT_NEXT(a_empty_pop, adv && is_pop && !found, status == ST_EMPTY && out_tick == '0, "empty pop wrong")

endmodule

### tb/kway_note_merge_tb.sv
`timescale 1ns / 1ps
// Testbench for kway_note_merge: directed and random push/pop transactions, checked
// against a per-slot list merge predictor kept in a small scoreboard class.
// Depends on kwm_pkg and the kway_note_merge RTL.
module kway_note_merge_tb;
	import kwm_pkg::*;

	localparam int SLOTS = 16;
	localparam int DEPTH = 1024;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		note_rec_t  rec;
	} merge_rsp_t;

	class note_merge_sb;
		note_rec_t  lists[SLOTS][$];
		merge_rsp_t due[$];
		int         errors = 0;

		function void note_cmd(logic c, logic [3:0] s, note_rec_t r);
			merge_rsp_t e;
			int best;
			e = '0;
			if (c == CMD_PUSH) begin
				e.slot = s;
				if (s >= SLOTS || lists[s].size() >= DEPTH) begin
					e.status = ST_FULL;
				end else begin
					lists[s].insert(lists[s].size(), r);
					e.status = ST_OK;
				end
			end else begin
				best = -1;
				for (int i = 0; i < SLOTS; i++)
					if (lists[i].size() != 0 &&
					    (best < 0 || lists[i][0].tick < lists[best][0].tick))
						best = i;
				if (best < 0) begin
					e.status = ST_EMPTY;
				end else begin
					e.status = ST_OK;
					e.slot = best[3:0];
					e.rec = lists[best].pop_front();
				end
			end
			due.insert(due.size(), e);
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_rsp(merge_rsp_t got);
			merge_rsp_t e;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0h slot %0h",
					$time, got.status, got.slot);
				return;
			end
			e = due.pop_front();
			cmp_field("status", e.status, got.status);
			cmp_field("out_slot", e.slot, got.slot);
			cmp_field("out_track", e.rec.track, got.rec.track);
			cmp_field("out_channel", e.rec.channel, got.rec.channel);
			cmp_field("out_tick", e.rec.tick, got.rec.tick);
			cmp_field("out_key", e.rec.key, got.rec.key);
			cmp_field("out_gate", e.rec.gate, got.rec.gate);
			cmp_field("out_velocity", e.rec.velocity, got.rec.velocity);
		endfunction

		function int pending();
			return due.size();
		endfunction

		function int stored();
			int n = 0;
			foreach (lists[i]) n += lists[i].size();
			return n;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic        cmd = CMD_PUSH;
	logic [3:0]  slot = '0;
	logic [15:0] note_track = '0;
	logic [3:0]  note_channel = '0;
	logic [31:0] note_tick = '0;
	logic [6:0]  note_key = '0;
	logic [31:0] note_gate = '0;
	logic [6:0]  note_velocity = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b1;
	logic [1:0]  status;
	logic [3:0]  out_slot;
	logic [15:0] out_track;
	logic [3:0]  out_channel;
	logic [31:0] out_tick;
	logic [6:0]  out_key;
	logic [31:0] out_gate;
	logic [6:0]  out_velocity;

	note_merge_sb sb;
	int           tx_gap_max = 13;
	int           rx_gap_max = 13;
	bit           hold_req = 1'b0;
	logic [31:0]  last_tick[SLOTS] = '{default: '0};

	kway_note_merge #(
		.NUM_SLOTS(SLOTS),
		.LIST_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.slot(slot),
		.note_track(note_track),
		.note_channel(note_channel),
		.note_tick(note_tick),
		.note_key(note_key),
		.note_gate(note_gate),
		.note_velocity(note_velocity),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.out_slot(out_slot),
		.out_track(out_track),
		.out_channel(out_channel),
		.out_tick(out_tick),
		.out_key(out_key),
		.out_gate(out_gate),
		.out_velocity(out_velocity)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ticks rise per slot with small steps so cross-slot ties are common
	function automatic note_rec_t rand_note(logic [3:0] s, bit wild);
		note_rec_t r;
		r.track = $urandom;
		r.channel = $urandom;
		r.key = $urandom;
		r.velocity = $urandom;
		r.gate = $urandom;
		if (wild) begin
			r.tick = $urandom;
		end else begin
			r.tick = last_tick[s] + $urandom_range(0, 3);
			last_tick[s] = r.tick;
		end
		return r;
	endfunction

	task automatic send(logic c, logic [3:0] s, note_rec_t r);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		slot <= s;
		note_track <= r.track;
		note_channel <= r.channel;
		note_tick <= r.tick;
		note_key <= r.key;
		note_gate <= r.gate;
		note_velocity <= r.velocity;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.note_cmd(c, s, r);
	endtask

	task automatic pop_note();
		send(CMD_POP, 4'($urandom), rand_note(4'd0, 1'b1));
	endtask

	initial begin
		int gap;
		merge_rsp_t got;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (200) @(posedge clk);
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			got.status = status;
			got.slot = out_slot;
			got.rec.track = out_track;
			got.rec.channel = out_channel;
			got.rec.tick = out_tick;
			got.rec.key = out_key;
			got.rec.gate = out_gate;
			got.rec.velocity = out_velocity;
			sb.check_rsp(got);
		end
	end

	initial begin
		#6_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		note_rec_t r;
		logic [3:0] s;
		logic [31:0] base;
		int pct;
		int n;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty pop, field extremes, tie on tick, push between pops
		send(CMD_POP, 4'd0, '0);
		send(CMD_PUSH, 4'd0, '0);
		send(CMD_PUSH, 4'd15, '1);
		r = rand_note(4'd0, 1'b1);
		r.tick = 32'd5;
		send(CMD_PUSH, 4'd7, r);
		r = rand_note(4'd0, 1'b1);
		r.tick = 32'd5;
		send(CMD_PUSH, 4'd3, r);
		r = rand_note(4'd0, 1'b1);
		r.tick = 32'd10;
		send(CMD_PUSH, 4'd1, r);
		pop_note();
		pop_note();
		r = rand_note(4'd0, 1'b1);
		r.tick = 32'd4;
		send(CMD_PUSH, 4'd2, r);
		repeat (6) pop_note();

		// random mixes of pushes and pops
		for (int ph = 0; ph < 10; ph++) begin
			pct = $urandom_range(30, 75);
			tx_gap_max = (ph % 3 == 1) ? 0 : 13;
			rx_gap_max = (ph % 4 == 2) ? 0 : 13;
			base = (ph % 2 == 1) ? 32'($urandom) : 32'd0;
			foreach (last_tick[i]) last_tick[i] = base + $urandom_range(0, 8);
			if (ph == 4) begin
				hold_req = 1'b1;
				tx_gap_max = 0;
			end
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(1, 100) <= pct) begin
					s = (ph == 6) ? 4'($urandom_range(0, 2)) : 4'($urandom);
					send(CMD_PUSH, s, rand_note(s, $urandom_range(1, 10) == 1));
				end else begin
					pop_note();
				end
			end
		end

		// drain every list
		tx_gap_max = 0;
		rx_gap_max = 2;
		n = sb.stored();
		repeat (n) pop_note();
		cmd_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
